// File: sv/legik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package legik_pkg;

    localparam int POS_W           = 16;
    localparam int ANG_W           = 16;
    localparam int LEN_W           = 14;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int CFG_IDX_W       = 2;
    localparam int Q_FRAC          = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COXA  = 2'd0,
        CFG_FEMUR = 2'd1,
        CFG_TIBIA = 2'd2
    } cfg_idx_t;

    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [2*LEN_W:0]   lensq_t;
    typedef logic [2*POS_W-1:0] m2_t;

    localparam len_t COXA_RST  = len_t'(5200);
    localparam len_t FEMUR_RST = len_t'(6600);
    localparam len_t TIBIA_RST = len_t'(13300);

    typedef struct packed {
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } pos_t;

    typedef logic signed [POS_W+1:0] t_t;

    localparam int SQ_IN_W  = 62;
    localparam int SQ_OUT_W = 32;
    localparam int SQ_STEPS = SQ_IN_W / 2;
    localparam int SQ_LAT   = SQ_STEPS + 1;
    typedef logic [SQ_IN_W-1:0]  sq_word_t;
    typedef logic [SQ_OUT_W-1:0] sq_out_t;

    localparam int DIV_W     = 44;
    localparam int DIV_Q_W   = Q_FRAC + 1;
    localparam int DIV_STEPS = Q_FRAC;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int C_W       = 32;
    typedef logic signed [DIV_W-1:0] div_num_t;
    typedef logic [DIV_W-1:0]        div_den_t;
    typedef logic signed [C_W-1:0]   c_t;

    localparam int COR_IN_W  = 34;
    localparam int COR_W     = 44;
    localparam int COR_Z_W   = 36;
    localparam int COR_STEPS = 31;
    localparam int COR_NORM  = 40;
    localparam int COR_LAT   = COR_STEPS + 4;
    typedef logic signed [COR_IN_W-1:0] cor_in_t;
    typedef logic signed [COR_W-1:0]    cor_t;
    typedef logic signed [COR_Z_W-1:0]  cor_z_t;

    localparam cor_z_t PI_Q30 = cor_z_t'(64'sd3373259426);

    localparam logic [31:0] ATAN_TAB [COR_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001
    };

    localparam int T_A = 1;
    localparam int T_R = T_A + SQ_LAT;
    localparam int T_T = T_R + 1;
    localparam int T_M = T_T + 1;
    localparam int T_Q = T_M + SQ_LAT;
    localparam int T_D = T_Q + 1;
    localparam int T_C = T_D + DIV_LAT;
    localparam int T_E = T_C + 1;
    localparam int T_F = T_E + 1;
    localparam int T_S = T_F + SQ_LAT;
    localparam int T_O = T_S + COR_LAT;
    localparam int T_G = T_O + 1;

endpackage
`default_nettype wire

// File: sv/leg_inverse_kinematics_3dof.sv
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// The depth is set by three 31-step square root chains, a 30-step divider and a
// 31-step CORDIC arctangent, all in series on the femur and tibia paths.
// Reset: rst_n clears all valid bits and loads the link lengths 5200, 6600, 13300.
`timescale 1ns / 1ps
`default_nettype none
module leg_inverse_kinematics_3dof (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // foot_x, foot_y, foot_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // coxa_angle, femur_angle, tibia_angle
    output logic             m_tuser,   // unreachable
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [13:0] cfg_data
);

    localparam int TA = legik_pkg::T_A;
    localparam int TT = legik_pkg::T_T;
    localparam int TM = legik_pkg::T_M;
    localparam int TQ = legik_pkg::T_Q;
    localparam int TE = legik_pkg::T_E;
    localparam int TS = legik_pkg::T_S;
    localparam int TO = legik_pkg::T_O;
    localparam int TG = legik_pkg::T_G;
    localparam int PW = legik_pkg::POS_W;
    localparam int ZW = legik_pkg::COR_Z_W + 1;
    localparam int RSH = legik_pkg::Q_FRAC - legik_pkg::ANGLE_FRAC_BITS;

    typedef logic signed [ZW-1:0] ang_t;

    localparam ang_t ANG_HALF = ang_t'(1) <<< (RSH - 1);
    localparam ang_t ANG_MAX  = ang_t'(2 ** (legik_pkg::ANG_W - 1) - 1);
    localparam ang_t ANG_MIN  = -ang_t'(2 ** (legik_pkg::ANG_W - 1));

    function automatic logic signed [legik_pkg::ANG_W-1:0] out_angle(input ang_t q);
        ang_t r;
        r = (q + ANG_HALF) >>> RSH;
        if (r > ANG_MAX)
        begin
            r = ANG_MAX;
        end
        else if (r < ANG_MIN)
        begin
            r = ANG_MIN;
        end
        return r[legik_pkg::ANG_W-1:0];
    endfunction

    logic en;

    legik_pkg::len_t   coxa_len_reg, femur_len_reg, tibia_len_reg;
    legik_pkg::lensq_t ff_reg, tt_reg, ft2_reg;

    logic                      vld_reg  [TA:TG];
    legik_pkg::pos_t           pos_reg  [TA:TS];
    logic [2*PW-1:0]           xy2_reg;
    legik_pkg::sq_out_t        r_q;
    legik_pkg::t_t             t_reg    [TT:TS];
    legik_pkg::m2_t            m2_reg   [TM:TQ];
    legik_pkg::sq_out_t        mq8_q;
    legik_pkg::div_num_t       num_reg  [2];
    legik_pkg::div_den_t       den_reg  [2];
    legik_pkg::c_t             div_c_reg   [2];
    logic                      div_bad_reg [2];
    legik_pkg::c_t             c_reg    [2][TE:TS];
    logic                      bad_reg  [2][TE:TO];
    legik_pkg::sq_word_t       csq_reg  [2];
    legik_pkg::sq_word_t       arg_reg  [2];
    legik_pkg::sq_out_t        s_q      [2];
    legik_pkg::cor_in_t        cy       [4];
    legik_pkg::cor_in_t        cx       [4];
    legik_pkg::cor_z_t         ang_q    [4];
    logic signed [legik_pkg::ANG_W-1:0] coxa_reg, femur_reg, tibia_reg;
    logic                      unr_reg;

    logic signed [2*PW-1:0]    xsq, ysq, zsq;
    logic signed [2*PW+3:0]    tsq;

    assign en       = !vld_reg[TG] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coxa_len_reg  <= legik_pkg::COXA_RST;
            femur_len_reg <= legik_pkg::FEMUR_RST;
            tibia_len_reg <= legik_pkg::TIBIA_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == legik_pkg::CFG_COXA)
            begin
                coxa_len_reg <= cfg_data;
            end
            else if (cfg_index == legik_pkg::CFG_FEMUR)
            begin
                femur_len_reg <= cfg_data;
            end
            else if (cfg_index == legik_pkg::CFG_TIBIA)
            begin
                tibia_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ff_reg  <= legik_pkg::lensq_t'(femur_len_reg) * legik_pkg::lensq_t'(femur_len_reg);
        tt_reg  <= legik_pkg::lensq_t'(tibia_len_reg) * legik_pkg::lensq_t'(tibia_len_reg);
        ft2_reg <= (legik_pkg::lensq_t'(femur_len_reg)
            * legik_pkg::lensq_t'(tibia_len_reg)) << 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = TA; k <= TG; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[TA] <= s_tvalid;
            for (int k = TA + 1; k <= TG; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_comb
    begin
        xsq = $signed(s_tdata[PW-1:0]) * $signed(s_tdata[PW-1:0]);
        ysq = $signed(s_tdata[2*PW-1:PW]) * $signed(s_tdata[2*PW-1:PW]);
        zsq = pos_reg[TT].z * pos_reg[TT].z;
        tsq = t_reg[TT] * t_reg[TT];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg[TA] <= s_tdata;
            xy2_reg     <= (2*PW)'(xsq) + (2*PW)'(ysq);
            for (int k = TA + 1; k <= TS; k++)
            begin
                pos_reg[k] <= pos_reg[k-1];
            end
            t_reg[TT] <= legik_pkg::t_t'({1'b0, r_q[PW:0]}) - legik_pkg::t_t'(coxa_len_reg);
            for (int k = TT + 1; k <= TS; k++)
            begin
                t_reg[k] <= t_reg[k-1];
            end
            m2_reg[TM] <= legik_pkg::m2_t'(tsq) + legik_pkg::m2_t'(zsq);
            for (int k = TM + 1; k <= TQ; k++)
            begin
                m2_reg[k] <= m2_reg[k-1];
            end
            num_reg[0] <= (legik_pkg::div_num_t'(ff_reg) + legik_pkg::div_num_t'(m2_reg[TQ])
                - legik_pkg::div_num_t'(tt_reg)) <<< 8;
            den_reg[0] <= (legik_pkg::div_den_t'(femur_len_reg)
                * legik_pkg::div_den_t'(mq8_q)) << 1;
            num_reg[1] <= legik_pkg::div_num_t'(ff_reg) + legik_pkg::div_num_t'(tt_reg)
                - legik_pkg::div_num_t'(m2_reg[TQ]);
            den_reg[1] <= legik_pkg::div_den_t'(ft2_reg);
        end
    end

    legik_sqrt u_sqrt_reach (
        .clk  (clk),
        .en   (en),
        .din  (legik_pkg::sq_word_t'(xy2_reg)),
        .dout (r_q)
    );

    legik_sqrt u_sqrt_dist (
        .clk  (clk),
        .en   (en),
        .din  (legik_pkg::sq_word_t'({m2_reg[TM], 16'b0})),
        .dout (mq8_q)
    );

    for (genvar l = 0; l < 2; l++) begin : g_div
        localparam int DS = legik_pkg::DIV_STEPS;
        localparam int DW = legik_pkg::DIV_W;

        logic [DW-1:0]  a_mag;
        logic [DW:0]    rem_reg   [0:DS];
        logic [DW-1:0]  dd_reg    [0:DS];
        logic [legik_pkg::DIV_Q_W-1:0] q_reg [0:DS];
        logic           neg_reg   [0:DS];
        logic           clamp_reg [0:DS];

        assign a_mag = num_reg[l][DW-1] ? DW'(-num_reg[l]) : DW'(num_reg[l]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                clamp_reg[0] <= (den_reg[l] == '0) || (a_mag > den_reg[l]);
                neg_reg[0]   <= num_reg[l][DW-1];
                dd_reg[0]    <= den_reg[l];
                q_reg[0]     <= legik_pkg::DIV_Q_W'(a_mag == den_reg[l]);
                rem_reg[0]   <= (a_mag == den_reg[l]) ? '0 : (DW+1)'(a_mag);
            end
        end

        for (genvar k = 1; k <= DS; k++) begin : g_step
            logic [DW:0] r2;
            assign r2 = {rem_reg[k-1][DW-1:0], 1'b0};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (r2 >= {1'b0, dd_reg[k-1]})
                    begin
                        rem_reg[k] <= r2 - {1'b0, dd_reg[k-1]};
                        q_reg[k]   <= {q_reg[k-1][legik_pkg::DIV_Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k] <= r2;
                        q_reg[k]   <= {q_reg[k-1][legik_pkg::DIV_Q_W-2:0], 1'b0};
                    end
                    dd_reg[k]    <= dd_reg[k-1];
                    neg_reg[k]   <= neg_reg[k-1];
                    clamp_reg[k] <= clamp_reg[k-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (clamp_reg[DS])
                begin
                    div_c_reg[l] <= neg_reg[DS]
                        ? -(legik_pkg::c_t'(1) <<< legik_pkg::Q_FRAC)
                        : (legik_pkg::c_t'(1) <<< legik_pkg::Q_FRAC);
                end
                else
                begin
                    div_c_reg[l] <= neg_reg[DS] ? -legik_pkg::c_t'(q_reg[DS])
                        : legik_pkg::c_t'(q_reg[DS]);
                end
                div_bad_reg[l] <= clamp_reg[DS];
            end
        end

        logic signed [2*legik_pkg::C_W-1:0] cprod;
        assign cprod = div_c_reg[l] * div_c_reg[l];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_reg[l][TE]   <= div_c_reg[l];
                bad_reg[l][TE] <= div_bad_reg[l];
                for (int k = TE + 1; k <= TS; k++)
                begin
                    c_reg[l][k] <= c_reg[l][k-1];
                end
                for (int k = TE + 1; k <= TO; k++)
                begin
                    bad_reg[l][k] <= bad_reg[l][k-1];
                end
                csq_reg[l] <= legik_pkg::sq_word_t'(cprod);
                arg_reg[l] <= (legik_pkg::sq_word_t'(1) << (2 * legik_pkg::Q_FRAC))
                    - csq_reg[l];
            end
        end

        legik_sqrt u_sqrt_acos (
            .clk  (clk),
            .en   (en),
            .din  (arg_reg[l]),
            .dout (s_q[l])
        );

        assign cy[l] = legik_pkg::cor_in_t'(s_q[l]);
        assign cx[l] = legik_pkg::cor_in_t'(c_reg[l][TS]);
    end

    assign cy[2] = legik_pkg::cor_in_t'(pos_reg[TS].z);
    assign cx[2] = legik_pkg::cor_in_t'(t_reg[TS]);
    assign cy[3] = legik_pkg::cor_in_t'(pos_reg[TS].y);
    assign cx[3] = legik_pkg::cor_in_t'(pos_reg[TS].x);

    for (genvar j = 0; j < 4; j++) begin : g_cordic
        legik_cordic u_cordic (
            .clk   (clk),
            .en    (en),
            .y_in  (cy[j]),
            .x_in  (cx[j]),
            .angle (ang_q[j])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coxa_reg  <= out_angle(ang_t'(ang_q[3]));
            femur_reg <= out_angle(ang_t'(ang_q[0]) - ang_t'(ang_q[2]));
            tibia_reg <= out_angle(ang_t'(ang_q[1]) - ang_t'(legik_pkg::PI_Q30));
            unr_reg   <= bad_reg[0][TO] | bad_reg[1][TO];
        end
    end

    assign m_tvalid = vld_reg[TG];
    assign m_tdata  = {tibia_reg, femur_reg, coxa_reg};
    assign m_tuser  = unr_reg;

endmodule
`default_nettype wire

// File: sv/legik_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module legik_sqrt (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire legik_pkg::sq_word_t  din,
    output legik_pkg::sq_out_t        dout
);

    legik_pkg::sq_word_t res_reg [0:legik_pkg::SQ_STEPS-1];
    legik_pkg::sq_word_t rem_reg [0:legik_pkg::SQ_STEPS-1];
    legik_pkg::sq_out_t  out_reg;

    for (genvar i = 0; i < legik_pkg::SQ_STEPS; i++) begin : g_step
        localparam legik_pkg::sq_word_t BIT_I =
            legik_pkg::sq_word_t'(1) << (legik_pkg::SQ_IN_W - 2 - 2 * i);
        legik_pkg::sq_word_t v_in;
        legik_pkg::sq_word_t r_in;
        legik_pkg::sq_word_t trial;

        if (i == 0) begin : g_first
            assign v_in = din;
            assign r_in = '0;
        end
        else begin : g_next
            assign v_in = rem_reg[i-1];
            assign r_in = res_reg[i-1];
        end

        assign trial = r_in + BIT_I;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_in >= trial)
                begin
                    rem_reg[i] <= v_in - trial;
                    res_reg[i] <= (r_in >> 1) + BIT_I;
                end
                else
                begin
                    rem_reg[i] <= v_in;
                    res_reg[i] <= r_in >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= legik_pkg::sq_out_t'(res_reg[legik_pkg::SQ_STEPS-1])
                + legik_pkg::sq_out_t'(rem_reg[legik_pkg::SQ_STEPS-1]
                    > res_reg[legik_pkg::SQ_STEPS-1]);
        end
    end

    assign dout = out_reg;

endmodule
`default_nettype wire

// File: sv/legik_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module legik_cordic (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire legik_pkg::cor_in_t y_in,
    input  wire legik_pkg::cor_in_t x_in,
    output legik_pkg::cor_z_t       angle
);

    localparam int EW   = legik_pkg::COR_IN_W + 1;
    localparam int SH_W = $clog2(legik_pkg::COR_NORM + 1);
    localparam int N    = legik_pkg::COR_STEPS;

    logic signed [EW-1:0] xw, yw, xf, yf;
    logic [EW-1:0]        ay, mx;
    legik_pkg::cor_z_t    base;

    logic signed [EW-1:0] s1_x_reg, s1_y_reg;
    logic [EW-1:0]        s1_mx_reg;
    legik_pkg::cor_z_t    s1_base_reg;
    logic                 s1_zero_reg;

    logic [SH_W-1:0]      msb;
    logic signed [EW-1:0] s2_x_reg, s2_y_reg;
    logic [SH_W-1:0]      s2_sh_reg;
    legik_pkg::cor_z_t    s2_base_reg;
    logic                 s2_zero_reg;

    legik_pkg::cor_t      x_reg    [0:N];
    legik_pkg::cor_t      y_reg    [0:N];
    legik_pkg::cor_z_t    z_reg    [0:N];
    legik_pkg::cor_z_t    base_reg [0:N];
    logic                 zero_reg [0:N];
    legik_pkg::cor_z_t    angle_reg;

    always_comb
    begin
        xw   = EW'(x_in);
        yw   = EW'(y_in);
        base = '0;
        xf   = xw;
        yf   = yw;
        if (xw < 0)
        begin
            base = (yw >= 0) ? legik_pkg::PI_Q30 : -legik_pkg::PI_Q30;
            xf   = -xw;
            yf   = -yw;
        end
        ay = (yf < 0) ? EW'(-yf) : EW'(yf);
        mx = (EW'(xf) > ay) ? EW'(xf) : ay;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg    <= xf;
            s1_y_reg    <= yf;
            s1_mx_reg   <= mx;
            s1_base_reg <= base;
            s1_zero_reg <= (x_in == 0) && (y_in == 0);
        end
    end

    always_comb
    begin
        msb = '0;
        for (int b = 0; b < EW; b++)
        begin
            if (s1_mx_reg[b])
            begin
                msb = SH_W'(b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_sh_reg   <= SH_W'(legik_pkg::COR_NORM) - msb;
            s2_base_reg <= s1_base_reg;
            s2_zero_reg <= s1_zero_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= legik_pkg::cor_t'(s2_x_reg) <<< s2_sh_reg;
            y_reg[0]    <= legik_pkg::cor_t'(s2_y_reg) <<< s2_sh_reg;
            z_reg[0]    <= '0;
            base_reg[0] <= s2_base_reg;
            zero_reg[0] <= s2_zero_reg;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam legik_pkg::cor_z_t ANG_I =
            legik_pkg::cor_z_t'({1'b0, legik_pkg::ATAN_TAB[i]});
        legik_pkg::cor_t xs, ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ANG_I;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ANG_I;
                end
                base_reg[i+1] <= base_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zero_reg[N] ? '0 : base_reg[N] + z_reg[N];
        end
    end

    assign angle = angle_reg;

endmodule
`default_nettype wire
